// ----- rtl/tbm_pkg.sv -----
// tbm_pkg: shared widths, stage counts, register indexes and the angle table
// for the terrain bias mask pixel unit
// no dependencies
package tbm_pkg;

  // sample format, heights and area weight are signed Q2.(SAMPLE_BITS-2)
  localparam int SAMPLE_BITS = 16;
  localparam int WIDE_SHIFT  = 32 - SAMPLE_BITS;
  localparam int DIFF_W      = SAMPLE_BITS + 1;
  localparam int GAIN_W      = 16;
  localparam int AREA_W      = SAMPLE_BITS - 1;
  localparam int AREA_ONE    = 1 << (SAMPLE_BITS - 2);

  // mask format, unsigned Q1.15
  localparam int MASK_W  = 16;
  localparam int ONE_Q15 = 32768;

  // datapath widths
  localparam int NORM_W  = 64;
  localparam int CORD_W  = 34;
  localparam int ANGLE_W = 18;
  localparam int REM_W   = 32;
  localparam int PROD_W  = MASK_W + AREA_W;
  localparam int ROUND_W = PROD_W + WIDE_SHIFT;

  // cell counts along the chain
  localparam int NORM_STEPS   = 6;
  localparam int SQRT_STEPS   = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int DIV_STEPS    = 16;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_BIAS_MODE    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BIAS_LEVEL   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_REVERSE_MASK = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_AREA_ENABLE  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_SLOPE_GAIN_X = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_SLOPE_GAIN_Y = 3'd5;

  // per-item values that ride beside the slope chain
  typedef struct packed {
    logic [MASK_W-1:0] alt;
    logic [AREA_W-1:0] area;
  } side_t;

  // atan(2^-i) as a fraction of 90 degrees, 65536 = 90 degrees
  function automatic logic signed [ANGLE_W-1:0] cordic_angle(input logic [3:0] idx);
    logic signed [ANGLE_W-1:0] a;
    case (idx)
      4'd0:    a = 18'sd32768;
      4'd1:    a = 18'sd19344;
      4'd2:    a = 18'sd10221;
      4'd3:    a = 18'sd5188;
      4'd4:    a = 18'sd2604;
      4'd5:    a = 18'sd1303;
      4'd6:    a = 18'sd652;
      4'd7:    a = 18'sd326;
      4'd8:    a = 18'sd163;
      4'd9:    a = 18'sd81;
      4'd10:   a = 18'sd41;
      4'd11:   a = 18'sd20;
      4'd12:   a = 18'sd10;
      4'd13:   a = 18'sd5;
      4'd14:   a = 18'sd3;
      4'd15:   a = 18'sd1;
      default: a = 18'sd0;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/terrain_bias_mask_pixel_unit.sv -----
// terrain_bias_mask_pixel_unit: top level of the heightfield slope/altitude mask
// depends on tbm_pkg, tbm_norm_cell, tbm_sqrt_cell, tbm_cordic_cell, tbm_div_cell
//
// One pixel is taken on every clock at which start is high; busy never rises, so
// start may be held high for a whole row. Each pixel produces one mask value on
// out_mask_value, marked by a one-cycle out_valid strobe, in pixel order. The
// receiver cannot stall the result and must capture it in that cycle. Each pixel
// passes through a fixed chain of cells: a 32-step square root, a 16-step angle
// cordic and a 16-step divider for the bias remap, plus the range reduction,
// squaring and area scaling stages. Register writes take effect on the next
// clock and must only be made while no pixel is in flight.
module terrain_bias_mask_pixel_unit (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  output logic                                      busy,
  input  logic signed [tbm_pkg::SAMPLE_BITS-1:0]    in_center_height,
  input  logic signed [tbm_pkg::SAMPLE_BITS-1:0]    in_left_height,
  input  logic signed [tbm_pkg::SAMPLE_BITS-1:0]    in_right_height,
  input  logic signed [tbm_pkg::SAMPLE_BITS-1:0]    in_down_height,
  input  logic signed [tbm_pkg::SAMPLE_BITS-1:0]    in_up_height,
  input  logic [1:0]                                in_span_x,
  input  logic [1:0]                                in_span_y,
  input  logic signed [tbm_pkg::SAMPLE_BITS-1:0]    in_area_weight,
  output logic                                      out_valid,
  output logic [tbm_pkg::MASK_W-1:0]                out_mask_value,
  input  logic                                      cfg_we,
  input  logic [tbm_pkg::CFG_ADDR_W-1:0]            cfg_addr,
  input  logic [tbm_pkg::CFG_DATA_W-1:0]            cfg_wdata
);

  localparam int NS = tbm_pkg::NORM_STEPS;
  localparam int SS = tbm_pkg::SQRT_STEPS;
  localparam int CS = tbm_pkg::CORDIC_STEPS;
  localparam int DS = tbm_pkg::DIV_STEPS;
  localparam int SB = tbm_pkg::SAMPLE_BITS;
  localparam int NW = tbm_pkg::NORM_W;
  localparam int CW = tbm_pkg::CORD_W;
  localparam int MW = tbm_pkg::MASK_W;
  // side line taps: the merge stage and the area scaling stage
  localparam int V_TAP      = 2 + NS + 2 + SS + 1 + NS + CS - 1;
  localparam int AREA_TAP   = V_TAP + 1 + DS + 1;
  localparam int SIDE_DEPTH = AREA_TAP + 1;
  localparam int HALF_LSB   = 1 << 29;

  logic accept;

  // configuration registers
  logic                             bias_mode_r;
  logic [MW-1:0]                    bias_level_r;
  logic                             reverse_mask_r;
  logic                             area_enable_r;
  logic [tbm_pkg::GAIN_W-1:0]       gain_x_r;
  logic [tbm_pkg::GAIN_W-1:0]       gain_y_r;

  // front end
  logic signed [tbm_pkg::DIFF_W-1:0] dx, dy;
  logic [tbm_pkg::DIFF_W-1:0]        dx_abs, dy_abs;
  logic signed [33:0]                hc_wide, alt_t;
  logic [MW-1:0]                     alt_v;
  logic [tbm_pkg::AREA_W-1:0]        area_v;
  logic                              valid_a_r;
  logic [tbm_pkg::DIFF_W-1:0]        dx_abs_a_r, dy_abs_a_r;
  logic [1:0]                        span_x_a_r, span_y_a_r;
  logic [tbm_pkg::DIFF_W+tbm_pkg::GAIN_W-1:0] px, py;
  logic [NW-1:0]                     nx_nxt, ny_nxt;
  logic                              valid_b_r;
  logic [NW-1:0]                     nx_b_r, ny_b_r;
  tbm_pkg::side_t                    side_r [0:SIDE_DEPTH-1];

  // first range reduction
  logic          n1_v [0:NS];
  logic [NW-1:0] n1_a [0:NS];
  logic [NW-1:0] n1_b [0:NS];
  logic [5:0]    n1_c [0:NS];

  // squares and sum
  logic          valid_sq_r, valid_sum_r;
  logic [61:0]   sq_x_r, sq_y_r;
  logic [5:0]    scale_sq_r, scale_sum_r;
  logic [NW-1:0] sum_r;

  // square root
  logic          sq_v [0:SS];
  logic [NW-1:0] sq_n [0:SS];
  logic [NW-1:0] sq_res [0:SS];
  logic [5:0]    sq_sc [0:SS];

  // magnitude and second range reduction
  logic          valid_m_r;
  logic [NW-1:0] mag_m_r;
  logic          n2_v [0:NS];
  logic [NW-1:0] n2_a [0:NS];
  logic [NW-1:0] n2_b [0:NS];
  logic [5:0]    n2_c [0:NS-1];

  // cordic
  logic                                c_v [0:CS];
  logic signed [CW-1:0]                c_x [0:CS];
  logic signed [CW-1:0]                c_y [0:CS];
  logic signed [tbm_pkg::ANGLE_W-1:0]  c_z [0:CS];
  logic                                c_zero [0:CS];

  // merge and bias divider
  logic signed [tbm_pkg::ANGLE_W-1:0]  zf;
  logic [MW-1:0]                       slope_v, v_sel, b_clamp, den_nxt;
  logic [tbm_pkg::REM_W-1:0]           num_nxt;
  logic                                valid_v_r;
  logic [tbm_pkg::REM_W-1:0]           num_v_r;
  logic [MW-1:0]                       den_v_r;
  logic                                d_v [0:DS];
  logic [tbm_pkg::REM_W-1:0]           d_rem [0:DS];
  logic [MW-1:0]                       d_den [0:DS];
  logic [MW-1:0]                       d_q [0:DS];

  // back end
  logic                                valid_f1_r, valid_f2_r, valid_f3_r;
  logic [MW-1:0]                       v2_f1_r, v2_f2_r;
  logic [tbm_pkg::PROD_W-1:0]          prod_f2_r;
  logic [tbm_pkg::ROUND_W-1:0]         rnd_sum;
  logic [MW-1:0]                       mask_r, mask_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_mode_r    <= 1'b0;
      bias_level_r   <= 16'd16384;
      reverse_mask_r <= 1'b0;
      area_enable_r  <= 1'b0;
      gain_x_r       <= 16'd256;
      gain_y_r       <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_addr)
        tbm_pkg::CFG_BIAS_MODE:    bias_mode_r    <= cfg_wdata[0];
        tbm_pkg::CFG_BIAS_LEVEL:   bias_level_r   <= cfg_wdata;
        tbm_pkg::CFG_REVERSE_MASK: reverse_mask_r <= cfg_wdata[0];
        tbm_pkg::CFG_AREA_ENABLE:  area_enable_r  <= cfg_wdata[0];
        tbm_pkg::CFG_SLOPE_GAIN_X: gain_x_r       <= cfg_wdata;
        tbm_pkg::CFG_SLOPE_GAIN_Y: gain_y_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // neighbor differences, altitude value and clamped area weight
  always_comb begin
    dx      = tbm_pkg::DIFF_W'(in_right_height) - tbm_pkg::DIFF_W'(in_left_height);
    dy      = tbm_pkg::DIFF_W'(in_up_height) - tbm_pkg::DIFF_W'(in_down_height);
    dx_abs  = dx[tbm_pkg::DIFF_W-1] ? tbm_pkg::DIFF_W'(-dx) : tbm_pkg::DIFF_W'(dx);
    dy_abs  = dy[tbm_pkg::DIFF_W-1] ? tbm_pkg::DIFF_W'(-dy) : tbm_pkg::DIFF_W'(dy);
    hc_wide = 34'(in_center_height) <<< tbm_pkg::WIDE_SHIFT;
    alt_t   = hc_wide + 34'sd1073741824;
    if (alt_t <= 34'sd0) begin
      alt_v = '0;
    end else if (alt_t[33:16] > 18'(tbm_pkg::ONE_Q15)) begin
      alt_v = MW'(tbm_pkg::ONE_Q15);
    end else begin
      alt_v = alt_t[31:16];
    end
    if (in_area_weight[SB-1]) begin
      area_v = '0;
    end else if (in_area_weight[SB-2:0] > tbm_pkg::AREA_W'(tbm_pkg::AREA_ONE)) begin
      area_v = tbm_pkg::AREA_W'(tbm_pkg::AREA_ONE);
    end else begin
      area_v = in_area_weight[SB-2:0];
    end
  end

  // stage a control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else begin
      valid_a_r <= accept;
    end
  end

  // stage a payload
  always_ff @(posedge clk) begin
    dx_abs_a_r <= dx_abs;
    dy_abs_a_r <= dy_abs;
    span_x_a_r <= in_span_x;
    span_y_a_r <= in_span_y;
  end

  // side line for altitude value and area weight
  always_ff @(posedge clk) begin
    side_r[0] <= '{alt: alt_v, area: area_v};
    for (int k = 1; k < SIDE_DEPTH; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  // gradient terms scaled by the axis gains
  always_comb begin
    px = (tbm_pkg::DIFF_W+tbm_pkg::GAIN_W)'(dx_abs_a_r) *
         (tbm_pkg::DIFF_W+tbm_pkg::GAIN_W)'(gain_x_r);
    py = (tbm_pkg::DIFF_W+tbm_pkg::GAIN_W)'(dy_abs_a_r) *
         (tbm_pkg::DIFF_W+tbm_pkg::GAIN_W)'(gain_y_r);
    nx_nxt = NW'(px) << tbm_pkg::WIDE_SHIFT;
    ny_nxt = NW'(py) << tbm_pkg::WIDE_SHIFT;
    if (span_x_a_r == 2'd1) begin
      nx_nxt = nx_nxt << 1;
    end
    if (span_y_a_r == 2'd1) begin
      ny_nxt = ny_nxt << 1;
    end
    if (span_x_a_r == 2'd0) begin
      nx_nxt = '0;
    end
    if (span_y_a_r == 2'd0) begin
      ny_nxt = '0;
    end
  end

  // stage b control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else begin
      valid_b_r <= valid_a_r;
    end
  end

  // stage b payload
  always_ff @(posedge clk) begin
    nx_b_r <= nx_nxt;
    ny_b_r <= ny_nxt;
  end

  // halve both terms until each is below 2^31
  assign n1_v[0] = valid_b_r;
  assign n1_a[0] = nx_b_r;
  assign n1_b[0] = ny_b_r;
  assign n1_c[0] = '0;

  for (genvar i = 0; i < NS; i++) begin : g_norm1
    tbm_norm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (n1_v[i]),
      .step_exp  (3'(NS - 1 - i)),
      .lim_exp   (6'd31),
      .a_in      (n1_a[i]),
      .b_in      (n1_b[i]),
      .cnt_in    (n1_c[i]),
      .out_valid (n1_v[i+1]),
      .a_out     (n1_a[i+1]),
      .b_out     (n1_b[i+1]),
      .cnt_out   (n1_c[i+1])
    );
  end

  // squares, then their sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_sq_r  <= 1'b0;
      valid_sum_r <= 1'b0;
    end else begin
      valid_sq_r  <= n1_v[NS];
      valid_sum_r <= valid_sq_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_x_r      <= 62'(n1_a[NS][30:0]) * 62'(n1_a[NS][30:0]);
    sq_y_r      <= 62'(n1_b[NS][30:0]) * 62'(n1_b[NS][30:0]);
    scale_sq_r  <= n1_c[NS];
    sum_r       <= NW'(sq_x_r) + NW'(sq_y_r);
    scale_sum_r <= scale_sq_r;
  end

  // integer square root, one result bit per cell
  assign sq_v[0]   = valid_sum_r;
  assign sq_n[0]   = sum_r;
  assign sq_res[0] = '0;
  assign sq_sc[0]  = scale_sum_r;

  for (genvar i = 0; i < SS; i++) begin : g_sqrt
    tbm_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_v[i]),
      .idx       (5'(i)),
      .n_in      (sq_n[i]),
      .res_in    (sq_res[i]),
      .scale_in  (sq_sc[i]),
      .out_valid (sq_v[i+1]),
      .n_out     (sq_n[i+1]),
      .res_out   (sq_res[i+1]),
      .scale_out (sq_sc[i+1])
    );
  end

  // magnitude restored to the gradient scale
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_m_r <= 1'b0;
    end else begin
      valid_m_r <= sq_v[SS];
    end
  end

  always_ff @(posedge clk) begin
    mag_m_r <= NW'(sq_res[SS][31:0]) << sq_sc[SS];
  end

  // halve unit and magnitude together until both are below 2^30
  assign n2_v[0] = valid_m_r;
  assign n2_a[0] = NW'(1) << 39;
  assign n2_b[0] = mag_m_r;
  assign n2_c[0] = '0;

  for (genvar i = 0; i < NS; i++) begin : g_norm2
    if (i < NS - 1) begin : g_mid
      tbm_norm_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (n2_v[i]),
        .step_exp  (3'(NS - 1 - i)),
        .lim_exp   (6'd30),
        .a_in      (n2_a[i]),
        .b_in      (n2_b[i]),
        .cnt_in    (n2_c[i]),
        .out_valid (n2_v[i+1]),
        .a_out     (n2_a[i+1]),
        .b_out     (n2_b[i+1]),
        .cnt_out   (n2_c[i+1])
      );
    end else begin : g_last
      tbm_norm_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (n2_v[i]),
        .step_exp  (3'(NS - 1 - i)),
        .lim_exp   (6'd30),
        .a_in      (n2_a[i]),
        .b_in      (n2_b[i]),
        .cnt_in    (n2_c[i]),
        .out_valid (n2_v[i+1]),
        .a_out     (n2_a[i+1]),
        .b_out     (n2_b[i+1]),
        .cnt_out   ()
      );
    end
  end

  // angle of (unit, magnitude), a flat slope is flagged and forced to zero
  assign c_v[0]    = n2_v[NS];
  assign c_x[0]    = $signed({1'b0, n2_a[NS][CW-2:0]});
  assign c_y[0]    = $signed({1'b0, n2_b[NS][CW-2:0]});
  assign c_z[0]    = '0;
  assign c_zero[0] = (n2_b[NS] == '0);

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    tbm_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (c_v[i]),
      .idx       (4'(i)),
      .x_in      (c_x[i]),
      .y_in      (c_y[i]),
      .z_in      (c_z[i]),
      .zero_in   (c_zero[i]),
      .out_valid (c_v[i+1]),
      .x_out     (c_x[i+1]),
      .y_out     (c_y[i+1]),
      .z_out     (c_z[i+1]),
      .zero_out  (c_zero[i+1])
    );
  end

  // mode select and bias remap setup
  always_comb begin
    zf = c_z[CS];
    if (c_zero[CS] || zf[tbm_pkg::ANGLE_W-1]) begin
      slope_v = '0;
    end else if (zf > 18'sd65536) begin
      slope_v = MW'(tbm_pkg::ONE_Q15);
    end else begin
      slope_v = MW'((17'(zf[16:0]) + 17'd1) >> 1);
    end
    v_sel   = bias_mode_r ? slope_v : side_r[V_TAP].alt;
    b_clamp = (bias_level_r > MW'(tbm_pkg::ONE_Q15)) ? MW'(tbm_pkg::ONE_Q15)
                                                     : bias_level_r;
    if (v_sel <= b_clamp) begin
      num_nxt = '0;
      den_nxt = MW'(1);
    end else begin
      den_nxt = MW'(17'(tbm_pkg::ONE_Q15) - 17'(b_clamp));
      num_nxt = (tbm_pkg::REM_W'(v_sel - b_clamp) << 15) + tbm_pkg::REM_W'(den_nxt >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_v_r <= 1'b0;
    end else begin
      valid_v_r <= c_v[CS];
    end
  end

  always_ff @(posedge clk) begin
    num_v_r <= num_nxt;
    den_v_r <= den_nxt;
  end

  // bias remap quotient, msb first
  assign d_v[0]   = valid_v_r;
  assign d_rem[0] = num_v_r;
  assign d_den[0] = den_v_r;
  assign d_q[0]   = '0;

  for (genvar i = 0; i < DS; i++) begin : g_div
    tbm_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (d_v[i]),
      .idx       (4'(DS - 1 - i)),
      .rem_in    (d_rem[i]),
      .den_in    (d_den[i]),
      .q_in      (d_q[i]),
      .out_valid (d_v[i+1]),
      .rem_out   (d_rem[i+1]),
      .den_out   (d_den[i+1]),
      .q_out     (d_q[i+1])
    );
  end

  // reversal, area product and rounding
  always_comb begin
    rnd_sum  = (tbm_pkg::ROUND_W'(prod_f2_r) << tbm_pkg::WIDE_SHIFT) +
               tbm_pkg::ROUND_W'(HALF_LSB);
    mask_nxt = area_enable_r ? rnd_sum[30 +: MW] : v2_f2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_f1_r <= 1'b0;
      valid_f2_r <= 1'b0;
      valid_f3_r <= 1'b0;
    end else begin
      valid_f1_r <= d_v[DS];
      valid_f2_r <= valid_f1_r;
      valid_f3_r <= valid_f2_r;
    end
  end

  always_ff @(posedge clk) begin
    v2_f1_r   <= reverse_mask_r ? MW'(17'(tbm_pkg::ONE_Q15) - 17'(d_q[DS])) : d_q[DS];
    prod_f2_r <= tbm_pkg::PROD_W'(v2_f1_r) * tbm_pkg::PROD_W'(side_r[AREA_TAP].area);
    v2_f2_r   <= v2_f1_r;
    mask_r    <= mask_nxt;
  end

  assign out_valid      = valid_f3_r;
  assign out_mask_value = mask_r;

endmodule

// ----- rtl/tbm_norm_cell.sv -----
// tbm_norm_cell: one step of a binary-weighted range reduction on a pair
// depends on tbm_pkg
module tbm_norm_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [2:0]                  step_exp,
  input  logic [5:0]                  lim_exp,
  input  logic [tbm_pkg::NORM_W-1:0]  a_in,
  input  logic [tbm_pkg::NORM_W-1:0]  b_in,
  input  logic [5:0]                  cnt_in,
  output logic                        out_valid,
  output logic [tbm_pkg::NORM_W-1:0]  a_out,
  output logic [tbm_pkg::NORM_W-1:0]  b_out,
  output logic [5:0]                  cnt_out
);

  logic [6:0]                 step;
  logic [6:0]                 shamt;
  logic                       big;
  logic                       valid_r;
  logic [tbm_pkg::NORM_W-1:0] a_r, a_nxt;
  logic [tbm_pkg::NORM_W-1:0] b_r, b_nxt;
  logic [5:0]                 cnt_r, cnt_nxt;

  // halve both by step when the pair still needs at least step halvings
  always_comb begin
    step    = 7'd1 << step_exp;
    shamt   = 7'(lim_exp) + step - 7'd1;
    big     = ((a_in | b_in) >> shamt) != '0;
    a_nxt   = big ? (a_in >> step) : a_in;
    b_nxt   = big ? (b_in >> step) : b_in;
    cnt_nxt = big ? (cnt_in + step[5:0]) : cnt_in;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    cnt_r <= cnt_nxt;
  end

  assign out_valid = valid_r;
  assign a_out     = a_r;
  assign b_out     = b_r;
  assign cnt_out   = cnt_r;

endmodule

// ----- rtl/tbm_sqrt_cell.sv -----
// tbm_sqrt_cell: one digit step of the integer square root
// depends on tbm_pkg
module tbm_sqrt_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [4:0]                  idx,
  input  logic [tbm_pkg::NORM_W-1:0]  n_in,
  input  logic [tbm_pkg::NORM_W-1:0]  res_in,
  input  logic [5:0]                  scale_in,
  output logic                        out_valid,
  output logic [tbm_pkg::NORM_W-1:0]  n_out,
  output logic [tbm_pkg::NORM_W-1:0]  res_out,
  output logic [5:0]                  scale_out
);

  logic [tbm_pkg::NORM_W-1:0] bit_v;
  logic [tbm_pkg::NORM_W-1:0] trial;
  logic                       valid_r;
  logic [tbm_pkg::NORM_W-1:0] n_r, n_nxt;
  logic [tbm_pkg::NORM_W-1:0] res_r, res_nxt;
  logic [5:0]                 scale_r;

  // test bit is 4^(31-idx)
  always_comb begin
    bit_v = tbm_pkg::NORM_W'(1) << (7'd62 - {1'b0, idx, 1'b0});
    trial = res_in + bit_v;
    if (n_in >= trial) begin
      n_nxt   = n_in - trial;
      res_nxt = (res_in >> 1) + bit_v;
    end else begin
      n_nxt   = n_in;
      res_nxt = res_in >> 1;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    res_r   <= res_nxt;
    scale_r <= scale_in;
  end

  assign out_valid = valid_r;
  assign n_out     = n_r;
  assign res_out   = res_r;
  assign scale_out = scale_r;

endmodule

// ----- rtl/tbm_cordic_cell.sv -----
// tbm_cordic_cell: one vectoring rotation of the angle cordic
// depends on tbm_pkg (angle table)
module tbm_cordic_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [3:0]                         idx,
  input  logic signed [tbm_pkg::CORD_W-1:0]  x_in,
  input  logic signed [tbm_pkg::CORD_W-1:0]  y_in,
  input  logic signed [tbm_pkg::ANGLE_W-1:0] z_in,
  input  logic                               zero_in,
  output logic                               out_valid,
  output logic signed [tbm_pkg::CORD_W-1:0]  x_out,
  output logic signed [tbm_pkg::CORD_W-1:0]  y_out,
  output logic signed [tbm_pkg::ANGLE_W-1:0] z_out,
  output logic                               zero_out
);

  logic signed [tbm_pkg::CORD_W-1:0]  xs, ys;
  logic signed [tbm_pkg::ANGLE_W-1:0] ang;
  logic                               valid_r;
  logic signed [tbm_pkg::CORD_W-1:0]  x_r, x_nxt;
  logic signed [tbm_pkg::CORD_W-1:0]  y_r, y_nxt;
  logic signed [tbm_pkg::ANGLE_W-1:0] z_r, z_nxt;
  logic                               zero_r;

  // rotate toward the x axis, floor shifts
  always_comb begin
    xs  = x_in >>> idx;
    ys  = y_in >>> idx;
    ang = tbm_pkg::cordic_angle(idx);
    if (!y_in[tbm_pkg::CORD_W-1]) begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + ang;
    end else begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - ang;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    zero_r <= zero_in;
  end

  assign out_valid = valid_r;
  assign x_out     = x_r;
  assign y_out     = y_r;
  assign z_out     = z_r;
  assign zero_out  = zero_r;

endmodule

// ----- rtl/tbm_div_cell.sv -----
// tbm_div_cell: one quotient bit of the restoring divider for the bias remap
// depends on tbm_pkg
module tbm_div_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [3:0]                  idx,
  input  logic [tbm_pkg::REM_W-1:0]   rem_in,
  input  logic [tbm_pkg::MASK_W-1:0]  den_in,
  input  logic [tbm_pkg::MASK_W-1:0]  q_in,
  output logic                        out_valid,
  output logic [tbm_pkg::REM_W-1:0]   rem_out,
  output logic [tbm_pkg::MASK_W-1:0]  den_out,
  output logic [tbm_pkg::MASK_W-1:0]  q_out
);

  logic [tbm_pkg::REM_W-1:0]  dsh;
  logic                       valid_r;
  logic [tbm_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [tbm_pkg::MASK_W-1:0] den_r;
  logic [tbm_pkg::MASK_W-1:0] q_r, q_nxt;

  // subtract the shifted divisor when it fits
  always_comb begin
    dsh = tbm_pkg::REM_W'(den_in) << idx;
    if (rem_in >= dsh) begin
      rem_nxt = rem_in - dsh;
      q_nxt   = q_in | (tbm_pkg::MASK_W'(1) << idx);
    end else begin
      rem_nxt = rem_in;
      q_nxt   = q_in;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_in;
    q_r   <= q_nxt;
  end

  assign out_valid = valid_r;
  assign rem_out   = rem_r;
  assign den_out   = den_r;
  assign q_out     = q_r;

endmodule
